// File: rtl/ihdp_pkg.sv
// Shared types, constants and signature tables for the image header dimension parser.
`timescale 1ns / 1ps

package ihdp_pkg;

    localparam int unsigned IDX_W = 5;

    // Byte offsets in the file
    localparam logic [IDX_W-1:0] PNG_SIG_LEN    = 5'd8;
    localparam logic [IDX_W-1:0] JPEG_SIG_LEN   = 5'd10;
    localparam logic [IDX_W-1:0] JPEG_LEN_HI_AT = 5'd4;
    localparam logic [IDX_W-1:0] JPEG_LEN_LO_AT = 5'd5;
    localparam logic [IDX_W-1:0] JPEG_SIG_LAST  = 5'd9;
    localparam logic [IDX_W-1:0] PNG_WIDTH_AT   = 5'h10;
    localparam logic [IDX_W-1:0] PNG_HEIGHT_AT  = 5'h14;
    localparam logic [IDX_W-1:0] PNG_LAST_AT    = 5'd23;
    localparam logic [IDX_W-1:0] INDEX_CAP      = 5'd24;

    // Marker bytes
    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] MARKER_SOF0   = 8'hC0;
    localparam logic [7:0] MARKER_SOF2   = 8'hC2;

    // Segment length limits
    localparam logic [15:0] SEG_LEN_MIN   = 16'd2;
    localparam logic [15:0] FIRST_LEN_MIN = 16'd6;

    // SOF body offsets
    localparam logic [2:0] SOF_HEIGHT_HI = 3'd3;
    localparam logic [2:0] SOF_HEIGHT_LO = 3'd4;
    localparam logic [2:0] SOF_WIDTH_HI  = 3'd5;
    localparam logic [2:0] SOF_WIDTH_LO  = 3'd6;

    typedef enum logic [2:0] {
        PH_SIG      = 3'd0,
        PH_SKIP     = 3'd1,
        PH_MARK0    = 3'd2,
        PH_MARK1    = 3'd3,
        PH_LENHI    = 3'd4,
        PH_LENLO    = 3'd5,
        PH_SOF      = 3'd6,
        PH_BADFIRST = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_PNG       = 3'd0,
        ST_JPEG      = 3'd1,
        ST_JPEG_BAD  = 3'd2,
        ST_NEITHER   = 3'd3,
        ST_PNG_SHORT = 3'd4
    } status_t;

    function automatic logic [7:0] png_sig_byte(input logic [2:0] pos);
        logic [7:0] val;
        begin
            case (pos)
                3'd0:    val = 8'd137;
                3'd1:    val = 8'h50;
                3'd2:    val = 8'h4E;
                3'd3:    val = 8'h47;
                3'd4:    val = 8'd13;
                3'd5:    val = 8'd10;
                3'd6:    val = 8'd26;
                3'd7:    val = 8'd10;
                default: val = 8'd0;
            endcase
            return val;
        end
    endfunction

    // Offsets 4 and 5 hold the first segment length and are never compared.
    function automatic logic [7:0] jpeg_sig_byte(input logic [3:0] pos);
        logic [7:0] val;
        begin
            case (pos)
                4'd0:    val = 8'hFF;
                4'd1:    val = 8'hD8;
                4'd2:    val = 8'hFF;
                4'd3:    val = 8'hE0;
                4'd6:    val = 8'h4A;
                4'd7:    val = 8'h46;
                4'd8:    val = 8'h49;
                4'd9:    val = 8'h46;
                default: val = 8'h00;
            endcase
            return val;
        end
    endfunction

endpackage

// File: rtl/ihdp_if.sv
// Valid/ready channel interfaces for file bytes in and dimension results out.
`timescale 1ns / 1ps

interface ihdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihdp_dim_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [30:0] width;
    logic [30:0] height;

    modport source (output valid, output status, output width, output height, input ready);
    modport sink   (input valid, input status, input width, input height, output ready);
endinterface

// File: rtl/image_header_dimension_parser.sv
// Top level: streaming PNG/JPEG header parser that reports image dimensions.
// Usage:
//   data : one file byte per beat, last_byte set on the final byte of a file.
//   dims : one beat per file at most, with status (0 png, 1 jpeg, 2 jpeg
//          malformed, 3 neither, 4 png truncated) and width/height in pixels.
// A byte is parsed in the cycle it is accepted; the result for it is
// registered and shows on dims the next cycle.
// Throughput is one byte per cycle while dims is not stalled: the parse state and result register are
// updated together, so the next byte can be taken in the following cycle.
// The result register is the only buffer. While it holds a beat that dims
// has not taken, data.ready stays low; it rises again in the cycle the beat
// is taken, so a taken result never costs a bubble.
// Once a file's result is out, further bytes are consumed and dropped until
// last_byte, which also rearms the parser for the next file.
// Reset (rst_n low, asynchronous) clears the parse state and drops any
// pending result.
`timescale 1ns / 1ps

module image_header_dimension_parser (
    input  logic               clk,
    input  logic               rst_n,
    ihdp_byte_if.sink          data,
    ihdp_dim_if.source         dims
);

    logic [ihdp_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       png_reg, png_next;
    logic                       jpeg_reg, jpeg_next;
    ihdp_pkg::phase_t           phase_reg, phase_next;
    logic [15:0]                skip_reg, skip_next;
    logic [7:0]                 lenhi_reg, lenhi_next;
    logic [2:0]                 sof_reg, sof_next;
    logic [31:0]                wacc_reg, wacc_next;
    logic [31:0]                hacc_reg, hacc_next;
    logic                       reported_reg, reported_next;

    logic                       out_valid_reg;
    ihdp_pkg::status_t          status_reg;
    logic [30:0]                width_reg;
    logic [30:0]                height_reg;

    logic                       accept;
    logic                       res_fire;
    ihdp_pkg::status_t          res_status;
    logic [30:0]                res_width;
    logic [30:0]                res_height;
    logic [7:0]                 b;
    logic [15:0]                seg_len;

    assign data.ready  = !out_valid_reg || dims.ready;
    assign accept      = data.valid && data.ready;
    assign b           = data.data_byte;
    assign seg_len     = {lenhi_reg, data.data_byte};

    assign dims.valid  = out_valid_reg;
    assign dims.status = status_reg;
    assign dims.width  = width_reg;
    assign dims.height = height_reg;

    always_comb
    begin
        idx_next      = idx_reg;
        png_next      = png_reg;
        jpeg_next     = jpeg_reg;
        phase_next    = phase_reg;
        skip_next     = skip_reg;
        lenhi_next    = lenhi_reg;
        sof_next      = sof_reg;
        wacc_next     = wacc_reg;
        hacc_next     = hacc_reg;
        reported_next = reported_reg;
        res_fire      = 1'b0;
        res_status    = ihdp_pkg::ST_NEITHER;
        res_width     = '0;
        res_height    = '0;

        if (accept)
        begin
            if (!reported_reg)
            begin
                if (idx_reg < ihdp_pkg::PNG_SIG_LEN
                    && b != ihdp_pkg::png_sig_byte(idx_reg[2:0]))
                    png_next = 1'b0;
                if (idx_reg < ihdp_pkg::JPEG_SIG_LEN
                    && idx_reg != ihdp_pkg::JPEG_LEN_HI_AT
                    && idx_reg != ihdp_pkg::JPEG_LEN_LO_AT
                    && b != ihdp_pkg::jpeg_sig_byte(idx_reg[3:0]))
                    jpeg_next = 1'b0;

                if (!png_next && !jpeg_next)
                begin
                    res_fire   = 1'b1;
                    res_status = ihdp_pkg::ST_NEITHER;
                end
                else if (png_next)
                begin
                    if (idx_reg >= ihdp_pkg::PNG_WIDTH_AT && idx_reg < ihdp_pkg::PNG_HEIGHT_AT)
                        wacc_next = {wacc_reg[23:0], b};
                    else if (idx_reg >= ihdp_pkg::PNG_HEIGHT_AT
                             && idx_reg < ihdp_pkg::INDEX_CAP)
                        hacc_next = {hacc_reg[23:0], b};
                    if (idx_reg == ihdp_pkg::PNG_LAST_AT)
                    begin
                        res_fire   = 1'b1;
                        res_status = ihdp_pkg::ST_PNG;
                        res_width  = wacc_next[30:0];
                        res_height = hacc_next[30:0];
                    end
                end
                else if (idx_reg == ihdp_pkg::JPEG_LEN_HI_AT)
                begin
                    lenhi_next = b;
                end
                else if (idx_reg == ihdp_pkg::JPEG_LEN_LO_AT)
                begin
                    // a first length under 6 would put the next marker inside the signature
                    if (seg_len < ihdp_pkg::FIRST_LEN_MIN)
                        phase_next = ihdp_pkg::PH_BADFIRST;
                    else if (seg_len == ihdp_pkg::SEG_LEN_MIN)
                        phase_next = ihdp_pkg::PH_MARK0;
                    else
                    begin
                        skip_next  = seg_len - ihdp_pkg::SEG_LEN_MIN;
                        phase_next = ihdp_pkg::PH_SKIP;
                    end
                end
                else if (phase_reg == ihdp_pkg::PH_BADFIRST)
                begin
                    if (idx_reg == ihdp_pkg::JPEG_SIG_LAST)
                    begin
                        res_fire   = 1'b1;
                        res_status = ihdp_pkg::ST_JPEG_BAD;
                    end
                end
                else
                begin
                    case (phase_reg)
                        ihdp_pkg::PH_SKIP:
                        begin
                            skip_next = skip_reg - 16'd1;
                            if (skip_next == 16'd0)
                                phase_next = ihdp_pkg::PH_MARK0;
                        end
                        ihdp_pkg::PH_MARK0:
                        begin
                            if (b != ihdp_pkg::MARKER_PREFIX)
                            begin
                                res_fire   = 1'b1;
                                res_status = ihdp_pkg::ST_JPEG_BAD;
                            end
                            else
                                phase_next = ihdp_pkg::PH_MARK1;
                        end
                        ihdp_pkg::PH_MARK1:
                        begin
                            if (b == ihdp_pkg::MARKER_SOF0 || b == ihdp_pkg::MARKER_SOF2)
                            begin
                                phase_next = ihdp_pkg::PH_SOF;
                                sof_next   = 3'd0;
                                wacc_next  = '0;
                                hacc_next  = '0;
                            end
                            else
                                phase_next = ihdp_pkg::PH_LENHI;
                        end
                        ihdp_pkg::PH_LENHI:
                        begin
                            lenhi_next = b;
                            phase_next = ihdp_pkg::PH_LENLO;
                        end
                        ihdp_pkg::PH_LENLO:
                        begin
                            if (seg_len < ihdp_pkg::SEG_LEN_MIN)
                            begin
                                res_fire   = 1'b1;
                                res_status = ihdp_pkg::ST_JPEG_BAD;
                            end
                            else if (seg_len == ihdp_pkg::SEG_LEN_MIN)
                                phase_next = ihdp_pkg::PH_MARK0;
                            else
                            begin
                                skip_next  = seg_len - ihdp_pkg::SEG_LEN_MIN;
                                phase_next = ihdp_pkg::PH_SKIP;
                            end
                        end
                        ihdp_pkg::PH_SOF:
                        begin
                            // body: length(2), precision, height(2), width(2)
                            if (sof_reg == ihdp_pkg::SOF_HEIGHT_HI
                                || sof_reg == ihdp_pkg::SOF_HEIGHT_LO)
                                hacc_next = {16'd0, hacc_reg[7:0], b};
                            else if (sof_reg == ihdp_pkg::SOF_WIDTH_HI
                                     || sof_reg == ihdp_pkg::SOF_WIDTH_LO)
                                wacc_next = {16'd0, wacc_reg[7:0], b};
                            if (sof_reg >= ihdp_pkg::SOF_WIDTH_LO)
                            begin
                                res_fire   = 1'b1;
                                res_status = ihdp_pkg::ST_JPEG;
                                res_width  = wacc_next[30:0];
                                res_height = hacc_next[30:0];
                            end
                            else
                                sof_next = sof_reg + 3'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (idx_reg < ihdp_pkg::INDEX_CAP)
                    idx_next = idx_reg + 5'd1;
                if (res_fire)
                    reported_next = 1'b1;
            end

            if (data.last_byte)
            begin
                if (!reported_reg && !res_fire)
                begin
                    res_fire = 1'b1;
                    if (png_next)
                        res_status = (idx_next >= ihdp_pkg::PNG_SIG_LEN)
                                     ? ihdp_pkg::ST_PNG_SHORT : ihdp_pkg::ST_NEITHER;
                    else if (jpeg_next)
                        res_status = (idx_next >= ihdp_pkg::JPEG_SIG_LEN)
                                     ? ihdp_pkg::ST_JPEG_BAD : ihdp_pkg::ST_NEITHER;
                    else
                        res_status = ihdp_pkg::ST_NEITHER;
                end
                // rearm for the next file
                idx_next      = '0;
                png_next      = 1'b1;
                jpeg_next     = 1'b1;
                phase_next    = ihdp_pkg::PH_SIG;
                skip_next     = '0;
                lenhi_next    = '0;
                sof_next      = '0;
                wacc_next     = '0;
                hacc_next     = '0;
                reported_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            png_reg      <= 1'b1;
            jpeg_reg     <= 1'b1;
            phase_reg    <= ihdp_pkg::PH_SIG;
            skip_reg     <= '0;
            lenhi_reg    <= '0;
            sof_reg      <= '0;
            wacc_reg     <= '0;
            hacc_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            png_reg      <= png_next;
            jpeg_reg     <= jpeg_next;
            phase_reg    <= phase_next;
            skip_reg     <= skip_next;
            lenhi_reg    <= lenhi_next;
            sof_reg      <= sof_next;
            wacc_reg     <= wacc_next;
            hacc_reg     <= hacc_next;
            reported_reg <= reported_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_fire)
            out_valid_reg <= 1'b1;
        else if (dims.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            status_reg <= res_status;
            width_reg  <= res_width;
            height_reg <= res_height;
        end
    end

`ifndef SYNTHESIS
    // a pending result blocks the byte side
    assert property (@(posedge clk) disable iff (!rst_n)
        dims.valid && !dims.ready |-> !data.ready)
        else $error("byte accepted while result stalled");

    // the signatures differ in the first byte, so at most one format survives it
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != '0 |-> !(png_reg && jpeg_reg))
        else $error("both formats still candidates after first byte");

    // segment walking only happens on a live JPEG stream
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != ihdp_pkg::PH_SIG && !reported_reg |-> jpeg_reg && !png_reg)
        else $error("segment phase active without a JPEG candidate");

    assert property (@(posedge clk) disable iff (!rst_n)
        sof_reg <= ihdp_pkg::SOF_WIDTH_LO)
        else $error("SOF offset ran past the width field");

    // a new result beat always follows an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dims.valid) |-> $past(data.valid && data.ready))
        else $error("result appeared without an accepted byte");
`endif

endmodule
